@@ hw/rtl/atsr_pkg.sv @@
package atsr_pkg;

  localparam int ANGLE_W    = 18;
  localparam int SCALE_W    = 16;
  localparam int OUT_W      = 18;
  localparam int WIDE_W     = 36;  // angle in Q.30, before wrapping
  localparam int RED_W      = 33;  // wrapped angle in [-pi, pi)
  localparam int Z_W        = 32;  // folded angle and residual angle
  localparam int XY_W       = 32;  // cordic vector components, Q.30
  localparam int PROD_W     = 48;  // scale times component
  localparam int FRAC_SHIFT = 30;
  localparam int WRAP_N     = 10;
  localparam int WRAP_IDX_W = 4;
  localparam int ATAN_N     = 32;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4096;

  localparam logic signed [RED_W-1:0] PI_Q30      = 33'sd3373259426;
  localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN_Q30 = 32'sd652032874;

  // odd multiples of pi: an angle at or above entry m lies past the m-th wrap boundary
  localparam logic signed [WIDE_W-1:0] WRAP_THRESH [WRAP_N] = '{
    -36'sd30359334834, -36'sd23612815982, -36'sd16866297130, -36'sd10119778278,
    -36'sd3373259426,   36'sd3373259426,   36'sd10119778278,  36'sd16866297130,
     36'sd23612815982,  36'sd30359334834
  };

  // whole turns to remove, picked by the number of boundaries passed
  localparam logic signed [WIDE_W-1:0] WRAP_OFFSET [WRAP_N+1] = '{
    -36'sd33732594260, -36'sd26986075408, -36'sd20239556556, -36'sd13493037704,
    -36'sd6746518852,   36'sd0,            36'sd6746518852,   36'sd13493037704,
     36'sd20239556556,  36'sd26986075408,  36'sd33732594260
  };

  localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_N] = '{
    32'sh3243F6A8, 32'sh1DAC6705, 32'sh0FADBAFC, 32'sh07F56EA6,
    32'sh03FEAB76, 32'sh01FFD55B, 32'sh00FFFAAA, 32'sh007FFF55,
    32'sh003FFFEA, 32'sh001FFFFD, 32'sh000FFFFF, 32'sh0007FFFF,
    32'sh0003FFFF, 32'sh0001FFFF, 32'sh0000FFFF, 32'sh00007FFF,
    32'sh00003FFF, 32'sh00001FFF, 32'sh00000FFF, 32'sh000007FF,
    32'sh000003FF, 32'sh000001FF, 32'sh000000FF, 32'sh0000007F,
    32'sh0000003F, 32'sh0000001F, 32'sh0000000F, 32'sh00000008,
    32'sh00000004, 32'sh00000002, 32'sh00000001, 32'sh00000000
  };

  localparam logic signed [PROD_W:0] ROUND_HALF     = 49'sd536870912;
  localparam logic signed [PROD_W:0] ROUND_HALF_INV = 49'sd536870913;
  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

  typedef struct packed {
    logic                  neg;
    logic signed [Z_W-1:0] z;
  } rot_req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] cos_s;
    logic signed [OUT_W-1:0] nsin_s;
    logic signed [OUT_W-1:0] sin_s;
  } matrix_t;

  // round half up from Q.42 to Q.12 and saturate; flip negates first (~p + 1)
  function automatic logic signed [OUT_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] p,
    input logic                     flip
  );
    logic signed [PROD_W:0]            opnd;
    logic signed [PROD_W:0]            sum;
    logic signed [PROD_W-FRAC_SHIFT:0] q;
    logic signed [OUT_W-1:0]           res;
    opnd = flip ? ~{p[PROD_W-1], p} : {p[PROD_W-1], p};
    sum  = opnd + (flip ? ROUND_HALF_INV : ROUND_HALF);
    q    = sum[PROD_W:FRAC_SHIFT];
    if (q > OUT_MAX) begin
      res = OUT_MAX;
    end else if (q < OUT_MIN) begin
      res = OUT_MIN;
    end else begin
      res = q[OUT_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/angle_to_scaled_rotation_matrix_top.sv @@
// Angle to scaled 2x3 rotation matrix. Each request carries one angle (signed Q5.12 radians)
// and yields one matrix [s*cos -s*sin 0; s*sin s*cos 0] in signed Q5.12, where s is the
// scale register (signed Q3.12, reset 1.0). The user must only write it over the cfg channel
// while idle; the block itself does not enforce this. A three-stage front end wraps the
// angle modulo 2*pi and folds it into [-pi/2, pi/2]; a four-entry queue feeds the back end,
// a ROTATION_STAGES-deep cordic pipeline followed by one multiply stage, which writes a
// two-entry result queue. Both sides take one request per cycle; the front stalls only when
// the middle queue is full and the back only when the result queue is full.
module angle_to_scaled_rotation_matrix_top #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [atsr_pkg::ANGLE_W-1:0] angle,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [atsr_pkg::OUT_W-1:0]   row0_col0,
  output logic signed [atsr_pkg::OUT_W-1:0]   row0_col1,
  output logic                                row0_col2,
  output logic signed [atsr_pkg::OUT_W-1:0]   row1_col0,
  output logic signed [atsr_pkg::OUT_W-1:0]   row1_col1,
  output logic                                row1_col2,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [atsr_pkg::SCALE_W-1:0] scale
);

  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;
  localparam int MID_W     = $bits(atsr_pkg::rot_req_t);
  localparam int OUT_W     = $bits(atsr_pkg::matrix_t);

  logic signed [atsr_pkg::SCALE_W-1:0] gain;

  logic                  mid_push;
  logic                  mid_full;
  logic                  mid_pop;
  logic                  mid_empty;
  atsr_pkg::rot_req_t    mid_wdata;
  logic [MID_W-1:0]      mid_rdata;
  atsr_pkg::rot_req_t    mid_head;

  logic                  out_push;
  logic                  out_full;
  atsr_pkg::matrix_t     out_wdata;
  logic [OUT_W-1:0]      out_rdata;
  atsr_pkg::matrix_t     out_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= atsr_pkg::SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain <= scale;
    end
  end

  atsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .angle    (angle),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  atsr_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_head = mid_rdata;

  atsr_back #(
    .STAGES (ROTATION_STAGES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .scale     (gain),
    .mid_empty (mid_empty),
    .mid_data  (mid_head),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  atsr_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_rdata),
    .empty (empty)
  );

  assign out_head  = out_rdata;
  assign row0_col0 = out_head.cos_s;
  assign row0_col1 = out_head.nsin_s;
  assign row0_col2 = 1'b0;
  assign row1_col0 = out_head.sin_s;
  assign row1_col1 = out_head.cos_s;
  assign row1_col2 = 1'b0;

endmodule

@@ hw/rtl/atsr_fifo.sv @@
module atsr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] wr_ptr;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == ADDR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == ADDR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/atsr_front.sv @@
module atsr_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [atsr_pkg::ANGLE_W-1:0] angle,
  input  logic                                mid_full,
  output logic                                mid_push,
  output atsr_pkg::rot_req_t                  mid_data
);

  localparam int WIDE_W = atsr_pkg::WIDE_W;
  localparam int RED_W  = atsr_pkg::RED_W;
  localparam int Z_W    = atsr_pkg::Z_W;

  logic                            en;
  logic signed [WIDE_W-1:0]        r_in;
  logic [atsr_pkg::WRAP_N-1:0]     ge_in;

  logic                            va;
  logic signed [WIDE_W-1:0]        r_a;
  logic [atsr_pkg::WRAP_N-1:0]     ge_a;

  logic [atsr_pkg::WRAP_IDX_W-1:0] turn_idx;
  logic signed [WIDE_W-1:0]        diff;
  logic                            vb;
  logic signed [RED_W-1:0]         r_b;

  logic signed [RED_W-1:0]         fold_up;
  logic signed [RED_W-1:0]         fold_dn;
  logic                            vc;
  logic                            neg_c;
  logic signed [Z_W-1:0]           z_c;

  assign en   = !mid_full;
  assign full = mid_full;
  assign r_in = {angle, {(WIDE_W - atsr_pkg::ANGLE_W){1'b0}}};

  // boundary compares are independent, so they all run in parallel
  for (genvar m = 0; m < atsr_pkg::WRAP_N; m++) begin : g_wrap
    assign ge_in[m] = (r_in >= atsr_pkg::WRAP_THRESH[m]);
  end

  // thermometer code: its weight is the number of turns to take off, offset by five
  assign turn_idx = atsr_pkg::WRAP_IDX_W'($countones(ge_a));
  assign diff     = r_a - atsr_pkg::WRAP_OFFSET[turn_idx];
  assign fold_up  = r_b - atsr_pkg::PI_Q30;
  assign fold_dn  = r_b + atsr_pkg::PI_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else if (en) begin
      va <= push;
      vb <= va;
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_a  <= r_in;
      ge_a <= ge_in;
      r_b  <= diff[RED_W-1:0];
      if (r_b > atsr_pkg::HALF_PI_Q30) begin
        z_c   <= fold_up[Z_W-1:0];
        neg_c <= 1'b1;
      end else if (r_b < -atsr_pkg::HALF_PI_Q30) begin
        z_c   <= fold_dn[Z_W-1:0];
        neg_c <= 1'b1;
      end else begin
        z_c   <= r_b[Z_W-1:0];
        neg_c <= 1'b0;
      end
    end
  end

  assign mid_push   = en && vc;
  assign mid_data.z = z_c;
  assign mid_data.neg = neg_c;

endmodule

@@ hw/rtl/atsr_back.sv @@
module atsr_back #(
  parameter int STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [atsr_pkg::SCALE_W-1:0] scale,
  input  logic                                mid_empty,
  input  atsr_pkg::rot_req_t                  mid_data,
  output logic                                mid_pop,
  input  logic                                out_full,
  output logic                                out_push,
  output atsr_pkg::matrix_t                   out_data
);

  localparam int XY_W   = atsr_pkg::XY_W;
  localparam int Z_W    = atsr_pkg::Z_W;
  localparam int PROD_W = atsr_pkg::PROD_W;

  logic                  en;

  logic signed [XY_W-1:0] x_in [STAGES];
  logic signed [XY_W-1:0] y_in [STAGES];
  logic signed [Z_W-1:0]  z_in [STAGES];
  logic                   n_in [STAGES];
  logic                   v_in [STAGES];

  logic signed [XY_W-1:0] xs  [STAGES];
  logic signed [XY_W-1:0] ys  [STAGES];
  logic signed [Z_W-1:0]  zs  [STAGES];
  logic                   ns  [STAGES];
  logic                   vld [STAGES];

  logic signed [PROD_W-1:0] pc_c;
  logic signed [PROD_W-1:0] ps_c;
  logic signed [PROD_W-1:0] pc_m;
  logic signed [PROD_W-1:0] ps_m;
  logic                     neg_m;
  logic                     vld_m;

  // whole back end stalls together when the result queue is full
  assign en      = !out_full;
  assign mid_pop = en && !mid_empty;

  for (genvar k = 0; k < STAGES; k++) begin : g_rot
    if (k == 0) begin : g_head
      assign x_in[k] = atsr_pkg::CORDIC_GAIN_Q30;
      assign y_in[k] = '0;
      assign z_in[k] = mid_data.z;
      assign n_in[k] = mid_data.neg;
      assign v_in[k] = !mid_empty;
    end else begin : g_link
      assign x_in[k] = xs[k-1];
      assign y_in[k] = ys[k-1];
      assign z_in[k] = zs[k-1];
      assign n_in[k] = ns[k-1];
      assign v_in[k] = vld[k-1];
    end

    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    assign dx = y_in[k] >>> k;
    assign dy = x_in[k] >>> k;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ns[k] <= n_in[k];
        if (!z_in[k][Z_W-1]) begin
          xs[k] <= x_in[k] - dx;
          ys[k] <= y_in[k] + dy;
          zs[k] <= z_in[k] - atsr_pkg::ATAN_Q30[k];
        end else begin
          xs[k] <= x_in[k] + dx;
          ys[k] <= y_in[k] - dy;
          zs[k] <= z_in[k] + atsr_pkg::ATAN_Q30[k];
        end
      end
    end
  end

  assign pc_c = scale * xs[STAGES-1];
  assign ps_c = scale * ys[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_m <= 1'b0;
    end else if (en) begin
      vld_m <= vld[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pc_m  <= pc_c;
      ps_m  <= ps_c;
      neg_m <= ns[STAGES-1];
    end
  end

  // the fold flag negates cos and sin; the negated entry flips once more
  assign out_data.cos_s  = atsr_pkg::round_sat(pc_m, neg_m);
  assign out_data.nsin_s = atsr_pkg::round_sat(ps_m, !neg_m);
  assign out_data.sin_s  = atsr_pkg::round_sat(ps_m, neg_m);
  assign out_push        = en && vld_m;

endmodule

@@ hw/rtl/atsr_checker.sv @@
module atsr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              empty,
  input logic                              pop,
  input logic signed [atsr_pkg::OUT_W-1:0] row0_col0,
  input logic signed [atsr_pkg::OUT_W-1:0] row0_col1,
  input logic signed [atsr_pkg::OUT_W-1:0] row1_col0,
  input logic signed [atsr_pkg::OUT_W-1:0] row1_col1
);

  logic signed [atsr_pkg::OUT_W:0] anti_sum;

  // rounding half up on both signs leaves the off-diagonal pair summing to 0 or 1
  assign anti_sum = (atsr_pkg::OUT_W + 1)'(row0_col1) + (atsr_pkg::OUT_W + 1)'(row1_col0);

  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result queue not empty after reset");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(row0_col0) && $stable(row0_col1)
                          && $stable(row1_col0)))
    else $error("waiting result changed before it was taken");

  a_diag_equal: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (row0_col0 == row1_col1))
    else $error("diagonal entries differ");

  a_antisym: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (anti_sum == '0 || anti_sum == (atsr_pkg::OUT_W + 1)'(1)))
    else $error("off-diagonal entries are not negatives of each other");

endmodule

bind angle_to_scaled_rotation_matrix_top atsr_checker u_atsr_checker (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .row0_col0 (row0_col0),
  .row0_col1 (row0_col1),
  .row1_col0 (row1_col0),
  .row1_col1 (row1_col1)
);

@@ bench/rotation_matrix_checker.sv @@
`timescale 1ns / 1ps

module rotation_matrix_checker #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  logic signed [atsr_pkg::ANGLE_W-1:0] angle,
  input  logic                                empty,
  input  logic                                pop,
  input  logic signed [atsr_pkg::OUT_W-1:0]   row0_col0,
  input  logic signed [atsr_pkg::OUT_W-1:0]   row0_col1,
  input  logic                                row0_col2,
  input  logic signed [atsr_pkg::OUT_W-1:0]   row1_col0,
  input  logic signed [atsr_pkg::OUT_W-1:0]   row1_col1,
  input  logic                                row1_col2,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic signed [atsr_pkg::SCALE_W-1:0] scale,
  output int                                  mismatches,
  output int                                  outstanding
);

  localparam int W = atsr_pkg::OUT_W;

  // angles held in Q.30
  localparam longint TURN_Q30         = 64'sd6746518852;
  localparam longint HALF_TURN_Q30    = 64'sd3373259426;
  localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
  localparam longint CORDIC_K_Q30     = 64'sd652032874;
  localparam longint SAT_HI           = 64'sd131071;
  localparam longint SAT_LO           = -64'sd131072;

  localparam longint ARCTAN_Q30 [32] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001, 'h00000000
  };

  typedef struct packed {
    logic signed [W-1:0] r0c0;
    logic signed [W-1:0] r0c1;
    logic                r0c2;
    logic signed [W-1:0] r1c0;
    logic signed [W-1:0] r1c1;
    logic                r1c2;
  } rot_matrix_t;

  logic signed [atsr_pkg::SCALE_W-1:0] gain = atsr_pkg::SCALE_RESET;
  rot_matrix_t                         pending_matrices[$];

  // Q.42 down to Q.12, round half up, then clamp to the field
  function automatic logic signed [W-1:0] round_to_q12(input longint p);
    longint q;
    q = (p + (64'sd1 <<< 29)) >>> 30;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q[W-1:0];
  endfunction

  function automatic rot_matrix_t predict_matrix(
    input logic signed [atsr_pkg::ANGLE_W-1:0] a,
    input logic signed [atsr_pkg::SCALE_W-1:0] s
  );
    rot_matrix_t m;
    longint      r;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    longint      pc;
    longint      ps;
    bit          flip;
    r = longint'(a) * 64'sd262144;
    r = r % TURN_Q30;
    if (r < 0) r += TURN_Q30;
    if (r >= HALF_TURN_Q30) r -= TURN_Q30;
    // fold into the right half plane, sine and cosine change sign
    flip = 1'b0;
    if (r > QUARTER_TURN_Q30) begin
      r -= HALF_TURN_Q30;
      flip = 1'b1;
    end else if (r < -QUARTER_TURN_Q30) begin
      r += HALF_TURN_Q30;
      flip = 1'b1;
    end
    x = CORDIC_K_Q30;
    y = 0;
    z = r;
    for (int i = 0; i < ROTATION_STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ARCTAN_Q30[i];
      end else begin
        x += dx;
        y -= dy;
        z += ARCTAN_Q30[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    pc = longint'(s) * x;
    ps = longint'(s) * y;
    m.r0c0 = round_to_q12(pc);
    m.r0c1 = round_to_q12(-ps);
    m.r0c2 = 1'b0;
    m.r1c0 = round_to_q12(ps);
    m.r1c1 = round_to_q12(pc);
    m.r1c2 = 1'b0;
    return m;
  endfunction

  function automatic int field_differs(
    input string               name,
    input logic signed [W-1:0] want,
    input logic signed [W-1:0] got
  );
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    rot_matrix_t want;
    int          bad;
    bad = 0;
    if (rst) begin
      gain = atsr_pkg::SCALE_RESET;
      pending_matrices.delete();
    end else begin
      if (cfg_valid && cfg_ready) gain = scale;
      if (pop && !empty) begin
        if (pending_matrices.size() == 0) begin
          $error("result popped with no request outstanding");
          bad = 1;
        end else begin
          want = pending_matrices.pop_front();
          bad += field_differs("row0_col0", want.r0c0, row0_col0);
          bad += field_differs("row0_col1", want.r0c1, row0_col1);
          bad += field_differs("row0_col2", W'(want.r0c2), W'(row0_col2));
          bad += field_differs("row1_col0", want.r1c0, row1_col0);
          bad += field_differs("row1_col1", want.r1c1, row1_col1);
          bad += field_differs("row1_col2", W'(want.r1c2), W'(row1_col2));
        end
      end
      if (push && !full) pending_matrices.push_back(predict_matrix(angle, gain));
    end
    mismatches  <= mismatches + bad;
    outstanding <= pending_matrices.size();
  end

endmodule

@@ bench/angle_to_scaled_rotation_matrix_top_tb.sv @@
`timescale 1ns / 1ps

module angle_to_scaled_rotation_matrix_top_tb;

  localparam int STAGES     = 16;
  localparam int LATENCY    = STAGES + 6;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_LEN  = 105;
  localparam int N_GAINS    = 9;

  // quarter-turn neighborhoods, turn wraps and field extremes
  localparam int EDGE_ANGLES [21] = '{
    0, 1, -1, 131071, -131072, 3217, 6433, 6434, -6433, -6434, 12867,
    12868, -12867, -12868, 19302, 19303, 25735, 25736, -25736, -25735, 102943
  };

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                push      = 1'b0;
  logic                                full;
  logic signed [atsr_pkg::ANGLE_W-1:0] angle     = '0;
  logic                                empty;
  logic                                pop       = 1'b0;
  logic signed [atsr_pkg::OUT_W-1:0]   row0_col0;
  logic signed [atsr_pkg::OUT_W-1:0]   row0_col1;
  logic                                row0_col2;
  logic signed [atsr_pkg::OUT_W-1:0]   row1_col0;
  logic signed [atsr_pkg::OUT_W-1:0]   row1_col1;
  logic                                row1_col2;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic signed [atsr_pkg::SCALE_W-1:0] scale     = '0;
  int                                  mismatches;
  int                                  outstanding;

  angle_to_scaled_rotation_matrix_top #(
    .ROTATION_STAGES(STAGES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .angle    (angle),
    .empty    (empty),
    .pop      (pop),
    .row0_col0(row0_col0),
    .row0_col1(row0_col1),
    .row0_col2(row0_col2),
    .row1_col0(row1_col0),
    .row1_col1(row1_col1),
    .row1_col2(row1_col2),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .scale    (scale)
  );

  rotation_matrix_checker #(
    .ROTATION_STAGES(STAGES)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .angle      (angle),
    .empty      (empty),
    .pop        (pop),
    .row0_col0  (row0_col0),
    .row0_col1  (row0_col1),
    .row0_col2  (row0_col2),
    .row1_col0  (row1_col0),
    .row1_col1  (row1_col1),
    .row1_col2  (row1_col2),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .scale      (scale),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic send_angle(input logic signed [atsr_pkg::ANGLE_W-1:0] a);
    @(negedge clk);
    push  <= 1'b1;
    angle <= a;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    @(negedge clk);
    push  <= 1'b0;
    angle <= atsr_pkg::ANGLE_W'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_scale(input logic signed [atsr_pkg::SCALE_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    scale     <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // mostly uniform, the rest clustered around multiples of a quarter turn
  function automatic logic signed [atsr_pkg::ANGLE_W-1:0] pick_angle();
    int k;
    if ($urandom_range(0, 9) < 7) return atsr_pkg::ANGLE_W'($urandom);
    k = int'($urandom_range(0, 40)) - 20;
    return atsr_pkg::ANGLE_W'(k * 6434 + int'($urandom_range(0, 16)) - 8);
  endfunction

  task automatic run_random(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_angle(pick_angle());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap > 0) idle_gap(gap);
    end
    idle_gap(1);
  endtask

  // result side: runs of steady pops, full stalls and random pops that fire three times in four
  initial begin
    int mode;
    int len;
    wait (!rst);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 40);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: pop <= 1'b1;
          1: pop <= 1'b0;
          default: pop <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // any request moving on any channel resets the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic signed [atsr_pkg::SCALE_W-1:0] gain_plan [N_GAINS];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_scale(16'sd4096);
    foreach (EDGE_ANGLES[i]) send_angle(atsr_pkg::ANGLE_W'(EDGE_ANGLES[i]));
    idle_gap(1);
    drain_results();

    gain_plan = '{16'sd32767, -16'sd32768, 16'sd0, -16'sd4096, 16'sd1, -16'sd1,
                  16'sd0, 16'sd0, 16'sd4096};
    gain_plan[6] = atsr_pkg::SCALE_W'($urandom_range(0, 65535));
    gain_plan[7] = atsr_pkg::SCALE_W'($urandom_range(0, 65535));
    foreach (gain_plan[p]) begin
      write_scale(gain_plan[p]);
      run_random(PHASE_LEN);
      drain_results();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
